FILE: rtl/core/lfu_cache_table_assert.svh
// assertion macros used by the lfu cache table checker
`ifndef LFU_CACHE_TABLE_ASSERT_SVH
`define LFU_CACHE_TABLE_ASSERT_SVH

// same-cycle implication, checked while dis is low
`define LCT_ASSERT_NOW(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("lct check failed");

// next-cycle implication, checked while dis is low
`define LCT_ASSERT_NEXT(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("lct check failed");

`endif

FILE: rtl/core/lct_pkg.sv
// types, constants and codes of the lfu cache table
package lct_pkg;

    // default table depth and configuration register layout
    localparam int unsigned DEF_ENTRIES = 16;
    localparam int unsigned CAP_W       = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // data widths
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned COUNT_W = 32;
    localparam int unsigned STAMP_W = 64;

    // operation codes
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // fixed result and count values
    localparam logic [DATA_W-1:0]  MISS_VALUE = '1;
    localparam logic [DATA_W-1:0]  PUT_VALUE  = '0;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
    localparam logic [COUNT_W-1:0] COUNT_NEW  = 32'd1;

    // input transaction
    typedef struct packed {
        logic                     op;
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] value;
    } t_in_item;

    // output transaction
    typedef struct packed {
        logic                     found;
        logic signed [DATA_W-1:0] read_value;
    } t_out_item;

    // one table entry
    typedef struct packed {
        logic [DATA_W-1:0]  key;
        logic [DATA_W-1:0]  value;
        logic [COUNT_W-1:0] count;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic issue;
        logic commit;
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_ctrl_sts;

endpackage

FILE: rtl/core/lct_ctrl.sv
// sequencing state machine of the lfu cache table
module lct_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lct_pkg::t_ctrl_sts  i_sts,
    output lct_pkg::t_ctrl_cmd  o_cmd
);

    lct_pkg::t_state r_state;
    lct_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lct_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lct_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = lct_pkg::ST_SCAN;
            end
            lct_pkg::ST_SCAN: begin
                if (i_sts.scan_done) n_state = lct_pkg::ST_COMMIT;
            end
            lct_pkg::ST_COMMIT: begin
                if (i_sts.out_free) n_state = lct_pkg::ST_IDLE;
            end
            default: begin
                n_state = lct_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            lct_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            lct_pkg::ST_SCAN: begin
                o_cmd.issue = !i_sts.scan_done;
            end
            lct_pkg::ST_COMMIT: begin
                o_cmd.commit = i_sts.out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

FILE: rtl/core/lct_datapath.sv
// entry store, scan compare, update and result register of the lfu cache table
module lct_datapath #(
    parameter int unsigned ENTRIES = lct_pkg::DEF_ENTRIES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lct_pkg::t_in_item               i_in_item,
    input  logic                            i_cfg_wr_en,
    input  logic [lct_pkg::CAP_W-1:0]       i_cfg_wr_data,
    input  lct_pkg::t_ctrl_cmd              i_cmd,
    output lct_pkg::t_ctrl_sts              o_sts,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output lct_pkg::t_out_item              o_out_item
);

    localparam int unsigned IW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned OW    = $clog2(ENTRIES + 1);
    localparam int unsigned CMP_W = (OW > lct_pkg::CAP_W) ? OW : lct_pkg::CAP_W;
    localparam logic [CMP_W-1:0] ENT_C = CMP_W'(ENTRIES);

    // entry store
    lct_pkg::t_entry r_store [ENTRIES];
    lct_pkg::t_entry r_rd_word;

    // configuration and global state
    logic [lct_pkg::CAP_W-1:0]   r_cap;
    logic [OW-1:0]               r_occ;
    logic [lct_pkg::STAMP_W-1:0] r_use_clock;

    // latched transaction
    lct_pkg::t_in_item r_item;

    // scan state
    logic [OW-1:0] r_idx;
    logic          r_rd_vld;
    logic [IW-1:0] r_rd_idx;

    // key match tracker
    logic                        r_match;
    logic [IW-1:0]               r_match_idx;
    logic [lct_pkg::DATA_W-1:0]  r_match_value;
    logic [lct_pkg::COUNT_W-1:0] r_match_count;

    // victim tracker
    logic                        r_have_vic;
    logic [IW-1:0]               r_vic_idx;
    logic [lct_pkg::COUNT_W-1:0] r_vic_count;
    logic [lct_pkg::STAMP_W-1:0] r_vic_stamp;

    // output register
    logic               r_out_valid;
    lct_pkg::t_out_item r_out_item;

    // commit decisions
    logic [CMP_W-1:0]            cap_ext;
    logic [CMP_W-1:0]            cap_eff;
    logic [CMP_W-1:0]            occ_ext;
    logic                        wr_en;
    logic                        occ_inc;
    logic [IW-1:0]               wr_addr;
    lct_pkg::t_entry             wr_word;
    lct_pkg::t_out_item          res;
    logic [lct_pkg::COUNT_W-1:0] cnt_inc;
    logic                        hit_key;
    logic                        better;

    // status to the controller
    assign o_sts.scan_done = (r_idx == r_occ);
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= lct_pkg::CAP_RESET;
        end else if (i_cfg_wr_en) begin
            r_cap <= i_cfg_wr_data;
        end
    end

    // store write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && wr_en) begin
            r_store[wr_addr] <= wr_word;
        end
        if (i_cmd.issue) begin
            r_rd_word <= r_store[r_idx[IW-1:0]];
        end
    end

    // latch transaction and read index
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_item;
        end
        r_rd_idx <= r_idx[IW-1:0];
    end

    // scan counter and read pipeline valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.issue;
            if (i_cmd.load) begin
                r_idx <= '0;
            end else if (i_cmd.issue) begin
                r_idx <= r_idx + OW'(1);
            end
        end
    end

    // compare of the entry just read
    assign hit_key = (r_rd_word.key == r_item.key);
    assign better  = !r_have_vic || (r_rd_word.count < r_vic_count) ||
                     ((r_rd_word.count == r_vic_count) && (r_rd_word.stamp < r_vic_stamp));

    // match and victim trackers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match    <= 1'b0;
            r_have_vic <= 1'b0;
        end else if (i_cmd.load) begin
            r_match    <= 1'b0;
            r_have_vic <= 1'b0;
        end else if (r_rd_vld) begin
            if (hit_key) begin
                r_match       <= 1'b1;
                r_match_idx   <= r_rd_idx;
                r_match_value <= r_rd_word.value;
                r_match_count <= r_rd_word.count;
            end
            if (better) begin
                r_have_vic  <= 1'b1;
                r_vic_idx   <= r_rd_idx;
                r_vic_count <= r_rd_word.count;
                r_vic_stamp <= r_rd_word.stamp;
            end
        end
    end

    // effective capacity and occupancy compare
    assign cap_ext = CMP_W'(r_cap);
    assign cap_eff = (cap_ext > ENT_C) ? ENT_C : cap_ext;
    assign occ_ext = CMP_W'(r_occ);
    assign cnt_inc = (r_match_count == lct_pkg::COUNT_MAX)
                   ? r_match_count
                   : r_match_count + lct_pkg::COUNT_W'(1);

    // result and entry update of the finished scan
    always_comb begin
        wr_en          = 1'b0;
        occ_inc        = 1'b0;
        wr_addr        = r_match_idx;
        wr_word.key    = r_item.key;
        wr_word.value  = r_item.value;
        wr_word.count  = cnt_inc;
        wr_word.stamp  = r_use_clock;
        res.found      = r_match;
        res.read_value = lct_pkg::PUT_VALUE;
        if (r_item.op == lct_pkg::OP_GET) begin
            if (r_match) begin
                res.read_value = r_match_value;
                wr_en          = 1'b1;
                wr_word.value  = r_match_value;
            end else begin
                res.read_value = lct_pkg::MISS_VALUE;
            end
        end else if (cap_eff != '0) begin
            wr_en = 1'b1;
            if (!r_match) begin
                wr_word.count = lct_pkg::COUNT_NEW;
                if (occ_ext >= cap_eff) begin
                    wr_addr = r_vic_idx;
                end else begin
                    wr_addr = r_occ[IW-1:0];
                    occ_inc = 1'b1;
                end
            end
        end
    end

    // occupancy and use clock
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_use_clock <= '0;
        end else if (i_cmd.commit) begin
            if (occ_inc) r_occ <= r_occ + OW'(1);
            if (wr_en) r_use_clock <= r_use_clock + lct_pkg::STAMP_W'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.commit) begin
            r_out_item <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

FILE: rtl/core/lfu_cache_table.sv
// lfu cache table: top level joining controller and datapath
//
// Fully associative key-value cache, least frequently used replacement with
// ties going to the least recently used entry. One input transaction (op,
// key, value) gives one output transaction (found, read_value).
// Input channel: i_in_valid / o_in_stall; a transaction is taken when valid
// is high and stall is low. The block works on one transaction at a time.
// Output channel: o_out_valid / i_out_stall through an output register, so
// the next transaction is taken while a result still waits to be read.
// The entry store is scanned one entry per cycle through its single read port
// over the occupied entries, then the update step writes the chosen entry and
// loads the output register; the block then returns to idle before it takes
// the next transaction. While the receiver stalls, a finished transaction
// waits in the update step until the output register frees up; the input
// stays stalled meanwhile. Configuration: i_cfg_wr_en / i_cfg_wr_data write
// the capacity limit; the user must write it only while the block is idle,
// which the block does not enforce. Reset (synchronous, active low) empties
// the table, clears the use clock and sets the capacity limit to 16.
module lfu_cache_table #(
    parameter int unsigned ENTRIES = lct_pkg::DEF_ENTRIES
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  lct_pkg::t_in_item          i_in_item,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output lct_pkg::t_out_item         o_out_item,
    input  logic                       i_cfg_wr_en,
    input  logic [lct_pkg::CAP_W-1:0]  i_cfg_wr_data
);

    lct_pkg::t_ctrl_cmd cmd;
    lct_pkg::t_ctrl_sts sts;

    // sequencing
    lct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // storage and compare
    lct_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_item     (i_in_item),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_item    (o_out_item)
    );

endmodule

FILE: rtl/core/lct_checker.sv
// port-level checks of the lfu cache table and their bind
`include "lfu_cache_table_assert.svh"

module lct_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input lct_pkg::t_out_item o_out_item
);

    // reset leaves no result pending and the input open
    `LCT_ASSERT_NEXT(a_reset_clears, i_clk, 1'b0, !i_rst_n, !o_out_valid && !o_in_stall)

    // one transaction at a time: input closes right after an accept
    `LCT_ASSERT_NEXT(a_busy_after_accept, i_clk, !i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // a miss reads back all ones for get or zero for put
    `LCT_ASSERT_NOW(a_miss_value, i_clk, !i_rst_n, o_out_valid && !o_out_item.found, o_out_item.read_value == 0 || o_out_item.read_value == -1)

    // a stalled result holds
    `LCT_ASSERT_NEXT(a_out_hold, i_clk, !i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item))

endmodule

bind lfu_cache_table lct_checker u_lct_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

FILE: verif/lfu_cache_table_test.sv
// self-checking testbench for the lfu cache table with its own cache predictor
module lfu_cache_table_test;

    localparam int unsigned ENTRIES = lct_pkg::DEF_ENTRIES;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_stall;
    lct_pkg::t_in_item         i_in_item;
    logic                      o_out_valid;
    logic                      i_out_stall;
    lct_pkg::t_out_item        o_out_item;
    logic                      i_cfg_wr_en;
    logic [lct_pkg::CAP_W-1:0] i_cfg_wr_data;

    lfu_cache_table #(
        .ENTRIES(ENTRIES)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_item(i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item(o_out_item),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data)
    );

    // predicted cache contents
    bit                          m_valid [ENTRIES];
    logic [lct_pkg::DATA_W-1:0]  m_key   [ENTRIES];
    logic [lct_pkg::DATA_W-1:0]  m_value [ENTRIES];
    logic [lct_pkg::COUNT_W-1:0] m_count [ENTRIES];
    logic [lct_pkg::STAMP_W-1:0] m_stamp [ENTRIES];
    logic [lct_pkg::STAMP_W-1:0] m_clock;
    int unsigned                 m_fill;
    logic [lct_pkg::CAP_W-1:0]   m_cap;

    // replies still owed by the block, oldest first
    lct_pkg::t_out_item replies_due [$];

    int  error_count;
    bit  calm;
    bit  hold_request;
    int  hold_left;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #3000000;
        $display("simulation failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        // keep the log readable on a badly broken build
        if (error_count < 200) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
        error_count++;
    endtask

    // count and stamp a hit entry
    function automatic void bump_entry(input int slot);
        if (m_count[slot] != lct_pkg::COUNT_MAX) begin
            m_count[slot] = m_count[slot] + 1;
        end
        m_stamp[slot] = m_clock;
        m_clock = m_clock + 1;
    endfunction

    // lowest (count, stamp) among valid entries, lowest index on a tie
    function automatic int pick_evictee();
        int best;
        best = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (m_valid[i] && (best < 0 || m_count[i] < m_count[best] ||
                (m_count[i] == m_count[best] && m_stamp[i] < m_stamp[best]))) begin
                best = i;
            end
        end
        return best;
    endfunction

    function automatic int lowest_free_slot();
        int slot;
        slot = -1;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!m_valid[i]) begin
                slot = i;
            end
        end
        return slot;
    endfunction

    // apply one transaction to the predicted cache and give the reply
    function automatic lct_pkg::t_out_item predict_access(input lct_pkg::t_in_item it);
        lct_pkg::t_out_item r;
        int                 hit;
        int                 slot;
        int unsigned        eff_cap;
        hit = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (hit < 0 && m_valid[i] && m_key[i] == it.key) begin
                hit = i;
            end
        end
        eff_cap = (m_cap > ENTRIES) ? ENTRIES : m_cap;
        r.found = (hit >= 0);
        r.read_value = lct_pkg::PUT_VALUE;
        if (it.op == lct_pkg::OP_GET) begin
            if (hit >= 0) begin
                r.read_value = m_value[hit];
                bump_entry(hit);
            end else begin
                r.read_value = lct_pkg::MISS_VALUE;
            end
        end else if (eff_cap != 0) begin
            if (hit >= 0) begin
                m_value[hit] = it.value;
                bump_entry(hit);
            end else begin
                // table at its limit evicts, otherwise fill the lowest hole
                if (m_fill >= eff_cap) begin
                    slot = pick_evictee();
                    if (slot < 0) begin
                        slot = lowest_free_slot();
                    end
                end else begin
                    slot = lowest_free_slot();
                    if (slot < 0) begin
                        slot = pick_evictee();
                    end else begin
                        m_fill++;
                    end
                end
                if (slot >= 0) begin
                    m_valid[slot] = 1'b1;
                    m_key[slot]   = it.key;
                    m_value[slot] = it.value;
                    m_count[slot] = lct_pkg::COUNT_NEW;
                    m_stamp[slot] = m_clock;
                    m_clock = m_clock + 1;
                end
            end
        end
        return r;
    endfunction

    // receiver: random stalls, calm stretches and one long hold-off
    initial begin
        i_out_stall = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_left = 300;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= !calm && ($urandom_range(99) < 29);
            end
        end
    end

    // check each accepted reply against the oldest prediction
    initial begin
        lct_pkg::t_out_item want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                if (replies_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected reply found=%0b value=%h",
                        o_out_item.found, o_out_item.read_value));
                end else begin
                    want = replies_due.pop_front();
                    if (o_out_item.found !== want.found) begin
                        report_mismatch($sformatf("found expected %0b got %0b",
                            want.found, o_out_item.found));
                    end
                    if (o_out_item.read_value !== want.read_value) begin
                        report_mismatch($sformatf("read_value expected %h got %h",
                            want.read_value, o_out_item.read_value));
                    end
                end
            end
        end
    end

    // offer one transaction, maybe after a random gap, and wait for it to be taken
    task automatic send_item(input logic op, input logic [lct_pkg::DATA_W-1:0] key,
                             input logic [lct_pkg::DATA_W-1:0] value);
        lct_pkg::t_in_item it;
        int                gap;
        it.op = op;
        it.key = key;
        it.value = value;
        if (!calm && $urandom_range(99) < 29) begin
            gap = $urandom_range(1, 4);
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                i_in_item <= {$urandom, $urandom, $urandom};
            end
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (o_in_stall);
        replies_due.push_back(predict_access(it));
    endtask

    // stop offering and wait for every owed reply
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (replies_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_capacity(input logic [lct_pkg::CAP_W-1:0] cap);
        drain();
        repeat (ENTRIES + 4) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= cap;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        i_cfg_wr_data <= $urandom;
        m_cap = cap;
    endtask

    // extreme keys and values, miss, hit and update
    task automatic test_extremes();
        write_capacity(lct_pkg::CAP_RESET);
        send_item(lct_pkg::OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        send_item(lct_pkg::OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(lct_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(lct_pkg::OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(lct_pkg::OP_PUT, 32'h0000_0000, 32'h0000_0000);
        send_item(lct_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000);
        send_item(lct_pkg::OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_item(lct_pkg::OP_GET, 32'hFFFF_FFFF, 32'h1234_5678);
        send_item(lct_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);
        send_item(lct_pkg::OP_PUT, 32'h0000_0000, 32'h1234_5678);
        send_item(lct_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);
        send_item(lct_pkg::OP_GET, 32'h0000_0001, 32'h0000_0000);
    endtask

    // limit below occupancy, least frequent victim and least recent tie-break
    task automatic test_eviction();
        write_capacity(5'd2);
        send_item(lct_pkg::OP_PUT, 32'h0000_0011, 32'hA5A5_0011);
        send_item(lct_pkg::OP_PUT, 32'h0000_0022, 32'hA5A5_0022);
        send_item(lct_pkg::OP_GET, 32'h0000_0011, 32'h0000_0000);
        send_item(lct_pkg::OP_PUT, 32'h0000_0033, 32'hA5A5_0033);
        send_item(lct_pkg::OP_GET, 32'h0000_0022, 32'h0000_0000);
        send_item(lct_pkg::OP_GET, 32'h0000_0011, 32'h0000_0000);
        send_item(lct_pkg::OP_GET, 32'h0000_0033, 32'h0000_0000);
    endtask

    // zero limit: puts do nothing, gets still hit
    task automatic test_zero_capacity();
        write_capacity(5'd0);
        send_item(lct_pkg::OP_PUT, 32'h0000_0000, 32'hDEAD_BEEF);
        send_item(lct_pkg::OP_PUT, 32'h0000_0044, 32'h0000_0044);
        send_item(lct_pkg::OP_GET, 32'h0000_0044, 32'h0000_0000);
        send_item(lct_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);
    endtask

    // long receiver hold-off while transactions keep coming
    task automatic test_output_holdoff();
        write_capacity(5'd16);
        @(posedge i_clk);
        hold_request = 1'b1;
        for (int i = 0; i < 10; i++) begin
            send_item(i[0] ? lct_pkg::OP_GET : lct_pkg::OP_PUT,
                      32'h0000_0100 + i[3:1], $urandom);
        end
        drain();
    endtask

    // random traffic over a small key pool so that hits and evictions happen
    task automatic test_random_traffic(input int count,
                                       input logic [lct_pkg::CAP_W-1:0] cap,
                                       input bit quiet);
        logic [lct_pkg::DATA_W-1:0] key_pool [24];
        logic [lct_pkg::DATA_W-1:0] key;
        logic [lct_pkg::DATA_W-1:0] value;
        int                         pool_size;
        write_capacity(cap);
        calm = quiet;
        pool_size = $urandom_range(4, 24);
        for (int i = 0; i < 24; i++) begin
            case ($urandom_range(7))
                0: key_pool[i] = 32'h8000_0000;
                1: key_pool[i] = 32'h7FFF_FFFF;
                2: key_pool[i] = 32'hFFFF_FFFF;
                3: key_pool[i] = 32'h0000_0000;
                default: key_pool[i] = $urandom;
            endcase
        end
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(9) == 0) begin
                key = $urandom;
            end else begin
                key = key_pool[$urandom_range(pool_size - 1)];
            end
            case ($urandom_range(9))
                0: value = 32'h8000_0000;
                1: value = 32'h7FFF_FFFF;
                2: value = 32'hFFFF_FFFF;
                3: value = 32'h0000_0000;
                default: value = $urandom;
            endcase
            send_item($urandom_range(1) ? lct_pkg::OP_PUT : lct_pkg::OP_GET, key, value);
        end
        drain();
        calm = 1'b0;
    endtask

    // main sequence
    initial begin
        error_count = 0;
        calm = 1'b0;
        hold_request = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            m_valid[i] = 1'b0;
            m_key[i] = '0;
            m_value[i] = '0;
            m_count[i] = '0;
            m_stamp[i] = '0;
        end
        m_clock = '0;
        m_fill = 0;
        m_cap = lct_pkg::CAP_RESET;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_extremes();
        test_eviction();
        test_zero_capacity();
        test_output_holdoff();
        test_random_traffic(100, 5'd16, 1'b0);
        test_random_traffic(90, 5'd1, 1'b0);
        test_random_traffic(100, 5'd3, 1'b0);
        test_random_traffic(100, 5'd31, 1'b0);
        test_random_traffic(90, 5'd17, 1'b0);
        test_random_traffic(60, 5'd0, 1'b0);
        test_random_traffic(100, 5'd16, 1'b1);
        test_random_traffic(80, 5'd8, 1'b0);
        test_random_traffic(80, $urandom_range(31), 1'b0);

        // let any stray reply show up before judging
        drain();
        repeat (ENTRIES + 8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/lct_pkg.sv
rtl/core/lct_ctrl.sv
rtl/core/lct_datapath.sv
rtl/core/lfu_cache_table.sv
rtl/core/lct_checker.sv
verif/lfu_cache_table_test.sv
